FILE: hdl/modular_exponentiation_assert.svh
// Assertion macros for the modular exponentiation block.
// No dependencies; expects clk and arst_n in the including module.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// checked only out of reset
`define MEXP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mexp_pkg.sv
// Types and constants shared by the modular exponentiation modules.
// No dependencies.
package mexp_pkg;

	localparam int OP_W = 64;

	typedef struct packed {
		logic [OP_W-1:0] base;
		logic [OP_W-1:0] exponent;
		logic [OP_W-1:0] modulus;
	} mexp_in_t;

	typedef struct packed {
		logic [OP_W-1:0] power_result;
		logic            modulus_error;
	} mexp_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RED,
		ST_SCAN,
		ST_MUL,
		ST_NEXT,
		ST_SQR,
		ST_DONE
	} mexp_state_t;

	// multiplicand selection at multiplier load
	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_MULTIPLY,
		OP_SQUARE
	} mexp_op_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_load;
		mexp_op_t op;
		logic     mul_step;
		logic     commit_acc;
		logic     commit_run;
		logic     shift_expo;
	} mexp_cmd_t;

	typedef struct packed {
		logic mod_zero;
		logic expo_zero;
		logic expo_lsb;
		logic upper_zero;
	} mexp_status_t;

endpackage

FILE: hdl/mexp_datapath.sv
// Datapath: operand registers and a bit-serial modular multiplier.
// Depends on mexp_pkg.
module mexp_datapath import mexp_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  mexp_in_t     operands,
	input  mexp_cmd_t    cmd,
	output mexp_status_t status,
	output mexp_out_t    result
);

	localparam int TW = W + 2;

	logic [W-1:0]  mod_q;
	logic [W-1:0]  expo_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  run_q;
	logic [W-1:0]  prod_q;
	logic [W-1:0]  mcand_q;
	logic [W-1:0]  mplier_q;
	logic [W-1:0]  mcand_d;
	logic [TW-1:0] sum;
	logic [TW-1:0] m1;
	logic [TW-1:0] m2;
	logic [W-1:0]  prod_d;

	// Horner step: prod = (2*prod + bit*mcand) mod m, sum stays below 3m
	always_comb begin
		m1  = TW'(mod_q);
		m2  = {1'b0, mod_q, 1'b0};
		sum = {1'b0, prod_q, 1'b0} + (mplier_q[W-1] ? TW'(mcand_q) : '0);
		if (sum >= m2) begin
			prod_d = W'(sum - m2);
		end else if (sum >= m1) begin
			prod_d = W'(sum - m1);
		end else begin
			prod_d = W'(sum);
		end
	end

	always_comb begin
		unique case (cmd.op)
			OP_REDUCE:   mcand_d = W'(1);
			OP_MULTIPLY: mcand_d = acc_q;
			OP_SQUARE:   mcand_d = run_q;
			default:     mcand_d = run_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mod_q  <= operands.modulus[W-1:0];
			expo_q <= operands.exponent[W-1:0];
			run_q  <= operands.base[W-1:0];
			acc_q  <= W'(1);
		end
		if (cmd.mul_load) begin
			mcand_q  <= mcand_d;
			mplier_q <= run_q;
			prod_q   <= '0;
		end
		if (cmd.mul_step) begin
			prod_q   <= prod_d;
			mplier_q <= {mplier_q[W-2:0], 1'b0};
		end
		if (cmd.commit_acc) begin
			acc_q <= prod_d;
		end
		if (cmd.commit_run) begin
			run_q <= prod_d;
		end
		if (cmd.shift_expo) begin
			expo_q <= {1'b0, expo_q[W-1:1]};
		end
	end

	assign status.mod_zero   = (mod_q == '0);
	assign status.expo_zero  = (expo_q == '0);
	assign status.expo_lsb   = expo_q[0];
	assign status.upper_zero = (expo_q[W-1:1] == '0);

	assign result.modulus_error = status.mod_zero;
	assign result.power_result  = status.mod_zero ? '0 : OP_W'(acc_q);

endmodule

FILE: hdl/mexp_ctrl.sv
// Controller: sequences reduction, multiply and square over exponent bits.
// Depends on mexp_pkg and modular_exponentiation_assert.svh.
`include "modular_exponentiation_assert.svh"

module mexp_ctrl import mexp_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  mexp_status_t status,
	output mexp_cmd_t    cmd,
	output logic         busy,
	output logic         done
);

	localparam int CW = $clog2(W);

	mexp_state_t   state_q;
	mexp_state_t   state_d;
	logic [CW-1:0] cnt_q;
	logic          last;

	assign last = (cnt_q == CW'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.mul_load) begin
				cnt_q <= '0;
			end else if (cmd.mul_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = OP_REDUCE;
		done    = 1'b0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				if (status.mod_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.mul_load = 1'b1;
					cmd.op       = OP_REDUCE;
					state_d      = ST_RED;
				end
			end
			ST_RED: begin
				cmd.mul_step = 1'b1;
				if (last) begin
					cmd.commit_run = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.expo_zero) begin
					state_d = ST_DONE;
				end else if (status.expo_lsb) begin
					cmd.mul_load = 1'b1;
					cmd.op       = OP_MULTIPLY;
					state_d      = ST_MUL;
				end else begin
					cmd.mul_load = 1'b1;
					cmd.op       = OP_SQUARE;
					state_d      = ST_SQR;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (last) begin
					cmd.commit_acc = 1'b1;
					state_d        = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (status.upper_zero) begin
					cmd.shift_expo = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					cmd.mul_load = 1'b1;
					cmd.op       = OP_SQUARE;
					state_d      = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.mul_step = 1'b1;
				if (last) begin
					cmd.commit_run = 1'b1;
					cmd.shift_expo = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`MEXP_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
	`MEXP_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
	`MEXP_ASSERT(a_load_clears_cnt, cmd.mul_load |=> (cnt_q == '0), "multiplier count not cleared")
	`MEXP_ASSERT_ALWAYS(a_commit_last, (cmd.commit_acc || cmd.commit_run) |-> (cmd.mul_step && last),
		"commit outside the last multiplier step")

endmodule

FILE: hdl/modular_exponentiation.sv
// Modular exponentiation, right-to-left binary method, W = OPERAND_WIDTH.
// A zero modulus skips the multiplier and goes straight to done; otherwise the run time
// is set by the bit-serial modular multiplier and by the exponent's bits.
// One word at a time: busy stays high until the done strobe cycle ends.
// Reset (arst_n low, asynchronous) returns the controller to idle.
// Depends on mexp_pkg, mexp_ctrl and mexp_datapath.
module modular_exponentiation import mexp_pkg::*; #(
	parameter int OPERAND_WIDTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  mexp_in_t  operands,
	output logic      busy,
	output logic      done,
	output mexp_out_t result
);

	mexp_cmd_t    cmd;
	mexp_status_t status;

	mexp_ctrl #(
		.W(OPERAND_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mexp_datapath #(
		.W(OPERAND_WIDTH)
	) u_dp (
		.clk      (clk),
		.operands (operands),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

FILE: test/modular_exponentiation_tb.sv
// Self-checking testbench for modular_exponentiation: directed and random operand words.
// Each word's expected power and modulus error are predicted locally and compared with the result.
// Depends on mexp_pkg and the modular_exponentiation RTL.
module modular_exponentiation_tb;
	import mexp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LAT = 2 * OP_W * OP_W + 3 * OP_W + 4;
	localparam int MAX_GAP = 24;
	localparam logic [OP_W-1:0] ALL1 = '1;
	localparam logic [OP_W-1:0] TOP = {1'b1, {(OP_W-1){1'b0}}};
	localparam logic [OP_W-1:0] PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	mexp_in_t  operands = '0;
	logic      busy;
	logic      done;
	mexp_out_t result;

	mexp_in_t  pending_words[$];
	mexp_out_t expected_results[$];
	mexp_out_t want;
	int        n_popped = 0;
	int        n_accepted = 0;
	int        total_words = 0;
	int        gap_left = 0;
	int        burst_left = 0;
	int        errors = 0;
	int        n_zero_mod = 0;
	int        n_zero_exp = 0;
	longint    cycles = 0;
	longint    limit = 64'd100_000_000;

	modular_exponentiation #(.OPERAND_WIDTH(OP_W)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operands (operands),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [OP_W-1:0] mul_reduce(logic [OP_W-1:0] x, logic [OP_W-1:0] y,
			logic [OP_W-1:0] m);
		logic [2*OP_W-1:0] prod;
		prod = {{OP_W{1'b0}}, x} * {{OP_W{1'b0}}, y};
		return OP_W'(prod % {{OP_W{1'b0}}, m});
	endfunction

	function automatic mexp_out_t mod_power(mexp_in_t w);
		logic [OP_W-1:0] e;
		logic [OP_W-1:0] acc;
		logic [OP_W-1:0] sq;
		mexp_out_t r;
		r = '0;
		if (w.modulus == '0) begin
			r.modulus_error = 1'b1;
			return r;
		end
		e = w.exponent;
		acc = OP_W'(1);
		sq = w.base;
		while (e != '0) begin
			if (e[0])
				acc = mul_reduce(acc, sq, w.modulus);
			sq = mul_reduce(sq, sq, w.modulus);
			e = e >> 1;
		end
		r.power_result = acc;
		return r;
	endfunction

	function automatic logic [OP_W-1:0] rand_word(int nbits);
		logic [OP_W-1:0] v;
		v = {$urandom, $urandom};
		if (nbits < OP_W)
			v = v & ((64'd1 << nbits) - 64'd1);
		return v;
	endfunction

	task automatic add_word(logic [OP_W-1:0] b, logic [OP_W-1:0] e, logic [OP_W-1:0] m);
		mexp_in_t w;
		w.base = b;
		w.exponent = e;
		w.modulus = m;
		pending_words.push_back(w);
	endtask

	// driver: one word in flight, start held until taken, bursts with gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || n_accepted == n_popped) begin
				if (gap_left > 0 || pending_words.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					start <= 1'b0;
					operands <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				end else begin
					operands <= pending_words.pop_front();
					start <= 1'b1;
					n_popped++;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
					end
				end
			end
		end
	end

	// monitor: predict on acceptance, check on done
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
				end else begin
					want = expected_results.pop_front();
					if (result.power_result !== want.power_result) begin
						errors++;
						$display("%0t: power_result expected %h actual %h", $time,
							want.power_result, result.power_result);
					end
					if (result.modulus_error !== want.modulus_error) begin
						errors++;
						$display("%0t: modulus_error expected %b actual %b", $time,
							want.modulus_error, result.modulus_error);
					end
				end
			end
			if (start && !busy) begin
				expected_results.push_back(mod_power(operands));
				n_accepted++;
				if (operands.modulus == '0)
					n_zero_mod++;
				else if (operands.exponent == '0)
					n_zero_exp++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > limit) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int kind;
		add_word(5, 0, 7);
		add_word(ALL1, 0, 1);
		add_word(9, 0, 0);
		add_word(ALL1, ALL1, 0);
		add_word(0, 0, 0);
		add_word(123, 5, 1);
		add_word(0, 0, 5);
		add_word(0, 3, 5);
		add_word(ALL1, ALL1, ALL1);
		add_word(ALL1, 1, 3);
		add_word(97, 2, 97);
		add_word(2, 10, 1000);
		add_word(3, TOP, PRIME);
		add_word(ALL1 - 1, 2, ALL1);
		add_word(ALL1, ALL1, TOP);
		add_word(12345, 1, ALL1);
		add_word(TOP, 3, TOP + 1);
		add_word(2, 63, TOP);
		add_word(7, ALL1, 2);
		add_word(1, ALL1, PRIME);
		// mostly narrow exponents to keep the run short; a share at full width
		repeat (80) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: add_word(rand_word(OP_W), rand_word(OP_W), 0);
				1: add_word(rand_word(OP_W), 0, rand_word($urandom_range(1, OP_W)));
				2, 3, 4: add_word(rand_word(OP_W), rand_word(OP_W), rand_word(OP_W));
				default: add_word(rand_word(OP_W), rand_word($urandom_range(1, 12)),
					rand_word($urandom_range(1, OP_W)));
			endcase
		end
		total_words = pending_words.size();
		limit = 4 * longint'(total_words) * (MAX_LAT + MAX_GAP + 4) + 10000;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_accepted != total_words)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4 * OP_W) @(posedge clk);

		$display("checked %0d words: %0d with zero modulus, %0d with zero exponent,", total_words,
			n_zero_mod, n_zero_exp);
		$display("the rest directed extremes and full or narrow random operands");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
